### rtl/core/dpuc_pkg.sv
package dpuc_pkg;

	typedef enum logic [1:0] {
		REQ_HEADER = 2'd0,
		REQ_PIXEL  = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_NODEV   = 3'd1,
		ST_SHORT   = 3'd2,
		ST_ROWS    = 3'd3,
		ST_LENGTH  = 3'd4,
		ST_WIDTH   = 3'd5,
		ST_BLACK   = 3'd6,
		ST_BUSY    = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_RECV,
		S_COMP_RD,
		S_COMP_WR,
		S_FLUSH,
		S_TICK_RD,
		S_OUT
	} state_t;

	localparam logic [7:0] CMD_ROW_WIN = 8'h75;
	localparam logic [7:0] CMD_COL_WIN = 8'h15;
	localparam logic [7:0] CMD_ZERO    = 8'h00;
	localparam logic [7:0] CMD_RAM_WR  = 8'h5c;
	localparam int         CMD_BYTES   = 6;

endpackage

### rtl/core/dpuc_div.sv
// Restoring divider, one quotient bit per cycle
module dpuc_div import dpuc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [5:0]  cnt_q;
	logic [16:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], quo_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[16]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("divider did not start");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !start) |=> (cnt_q == $past(cnt_q) - 6'd1))
		else $error("divider count slipped");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !busy) else $error("divider woke up alone");
endmodule

### rtl/core/display_partial_update_compositor.sv
// Header: checked, then divided in the one-bit-per-cycle divider before the next transfer.
// Pixel byte: the last one also loads the status register and holds off input.
// Compositing: each copied byte takes a staging read, then a frame write.
// Tick: frame byte read in S_TICK_RD, result loaded in S_OUT; next tick taken back in S_FLUSH.
// Reset clears control state at once; the frame store is cleared by a pass over all
// DISPLAYS*DISPLAY_ROWS_N*ROW_BYTES bytes (21760 by default) before items are taken.
module display_partial_update_compositor import dpuc_pkg::*; #(
	parameter int DISPLAY_ROWS_N = 64,
	parameter int ROW_BYTES      = 170,
	parameter int CHUNK_BYTES    = 508,
	parameter int DISPLAYS       = 2,
	parameter int HEADER_BYTES   = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic        display_select,
	input  logic [15:0] row_origin,
	input  logic [15:0] col_origin,
	input  logic [15:0] row_count,
	input  logic [31:0] pixel_count,
	input  logic [31:0] message_length,
	input  logic [7:0]  pixel_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [2:0]  status,
	output logic [7:0]  out_byte,
	output logic [1:0]  out_channel,
	output logic        packet_end,
	output logic        frame_end
);
	localparam int FB      = DISPLAY_ROWS_N * ROW_BYTES;
	localparam int FBW     = $clog2(FB + 1);
	localparam int AW      = $clog2(FB);
	localparam int FA      = (DISPLAYS > 1) ? AW + 1 : AW;
	localparam int FDEPTH  = DISPLAYS * FB;
	localparam int TOTAL   = CMD_BYTES + 1 + FB;
	localparam int PW      = $clog2(TOTAL + 1);
	localparam int CW      = $clog2(CHUNK_BYTES + 1);
	localparam int RW      = $clog2(DISPLAY_ROWS_N + 1);
	localparam int BW      = $clog2(ROW_BYTES + 1);
	localparam logic [7:0] ROWS_M1 = 8'(DISPLAY_ROWS_N - 1);
	localparam logic [7:0] COLS_M1 = 8'(ROW_BYTES / 2 - 1);

	logic [7:0] frame_mem [FDEPTH];
	logic [7:0] stage_mem [FB];

	state_t state_q, state_d;
	logic        dev_q;
	logic        clr_q;
	logic [FA:0] clr_addr_q;

	// captured header
	logic        hdr_disp_q;
	logic [15:0] hdr_row_q, hdr_cnt_q;
	logic [16:0] hdr_bx_q;
	logic [31:0] hdr_pix_q, hdr_len_q;

	logic          upd_disp_q;
	logic [RW-1:0] upd_row_q, upd_h_q;
	logic [BW-1:0] upd_bx_q, upd_w_q;
	logic [31:0]   remain_q;
	logic [FBW-1:0] recv_q, used_q;
	logic          zero_q;
	logic [PW-1:0] fpos_q;

	// compositing walk
	logic [RW-1:0] c_row_q;
	logic [BW-1:0] c_col_q;
	logic [FBW-1:0] c_src_q;
	logic [FBW-1:0] c_dst_q;

	// output register
	logic       ovalid_q;
	logic       okind_q;
	logic [2:0] ost_q;
	logic [7:0] obyte_q;
	logic [1:0] och_q;
	logic       ope_q, ofe_q;

	logic [7:0] frd_q, srd_q;

	logic div_start, div_busy;
	logic [31:0] quot;

	dpuc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(hdr_pix_q), .divisor(hdr_cnt_q),
		.busy(div_busy), .quotient(quot)
	);

	logic acc_in, acc_out;
	assign in_stall  = clr_q || ovalid_q || (state_q != S_IDLE && state_q != S_RECV
		&& state_q != S_FLUSH);
	assign acc_in    = in_valid && !in_stall;
	assign acc_out   = ovalid_q && !out_stall;
	assign cfg_ready = 1'b1;

	// header arithmetic: col/3*2 by reciprocal multiply (16-bit * 43691 fits in 32 bits)
	logic [16:0] bx_calc;
	assign bx_calc = 17'((32'(col_origin) * 32'd43691 >> 17) * 2);

	logic [1:0] base;
	assign base = upd_disp_q ? 2'd2 : 2'd0;

	logic [FA-1:0] disp_off;
	assign disp_off = (DISPLAYS > 1 && upd_disp_q) ? FA'(FB) : '0;

	// check evaluation
	logic [2:0] chk_status;
	logic       chk_fail;
	always_comb begin
		chk_fail = 1'b1;
		chk_status = ST_DONE;
		priority if (!dev_q) chk_status = ST_NODEV;
		else if (hdr_len_q < 32'(HEADER_BYTES + 1)) chk_status = ST_SHORT;
		else if (hdr_cnt_q == '0 ||
			(17'(hdr_row_q) + 17'(hdr_cnt_q)) > 17'(DISPLAY_ROWS_N))
			chk_status = ST_ROWS;
		else if (hdr_pix_q == '0 ||
			(33'(hdr_pix_q) + 33'(HEADER_BYTES)) > 33'(hdr_len_q))
			chk_status = ST_LENGTH;
		else chk_fail = 1'b0;
	end

	logic w_bad;
	assign w_bad = (quot == '0) || (33'(hdr_bx_q) + 33'(quot) > 33'(ROW_BYTES));

	// next state
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE, S_RECV: begin
				if (acc_in && req_type == REQ_HEADER) state_d = S_CHECK;
				else if (acc_in && req_type == REQ_PIXEL && state_q == S_RECV
					&& remain_q == 32'd1 && !(zero_q && pixel_byte == 8'd0))
					state_d = S_COMP_RD;
				else if (acc_in && req_type == REQ_PIXEL && state_q == S_RECV
					&& remain_q == 32'd1)
					state_d = S_IDLE;
			end
			S_CHECK: begin
				if (chk_fail) state_d = S_IDLE;
				else begin
					state_d = S_DIV;
					div_start = 1'b1;
				end
			end
			S_DIV: if (!div_busy) state_d = w_bad ? S_IDLE : S_RECV;
			S_COMP_RD: state_d = S_COMP_WR;
			S_COMP_WR: begin
				if (c_col_q == upd_w_q - BW'(1) && c_row_q == upd_h_q - RW'(1))
					state_d = S_FLUSH;
				else state_d = S_COMP_RD;
			end
			S_FLUSH: if (acc_in && req_type == REQ_TICK) state_d = S_TICK_RD;
			S_TICK_RD: state_d = S_OUT;
			S_OUT: state_d = (fpos_q == PW'(TOTAL - 1)) ? S_IDLE : S_FLUSH;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dev_q <= 1'b0;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) dev_q <= cfg_data;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == (FA+1)'(FDEPTH - 1)) clr_q <= 1'b0;
			end
		end
	end

	// header capture and datapath registers
	logic [FA-1:0] fa_rd;
	assign fa_rd = disp_off + FA'(fpos_q - PW'(CMD_BYTES + 1));

	always_ff @(posedge clk) begin
		if (acc_in && req_type == REQ_HEADER && state_q != S_FLUSH) begin
			hdr_disp_q <= (DISPLAYS > 1) ? display_select : 1'b0;
			hdr_row_q <= row_origin;
			hdr_cnt_q <= row_count;
			hdr_bx_q  <= bx_calc;
			hdr_pix_q <= pixel_count;
			hdr_len_q <= message_length;
		end
		if (state_q == S_DIV && !div_busy && !w_bad) begin
			upd_disp_q <= hdr_disp_q;
			upd_row_q  <= RW'(hdr_row_q);
			upd_h_q    <= RW'(hdr_cnt_q);
			upd_bx_q   <= BW'(hdr_bx_q);
			upd_w_q    <= BW'(quot);
			used_q     <= FBW'(32'(hdr_cnt_q) * quot);
			remain_q   <= hdr_pix_q;
			recv_q     <= '0;
			zero_q     <= 1'b1;
		end
		if (acc_in && req_type == REQ_PIXEL && state_q == S_RECV) begin
			if (recv_q < used_q) stage_mem[AW'(recv_q)] <= pixel_byte;
			if (recv_q < FBW'(FB)) recv_q <= recv_q + 1'b1;
			if (pixel_byte != 8'd0) zero_q <= 1'b0;
			remain_q <= remain_q - 32'd1;
			c_row_q <= '0;
			c_col_q <= '0;
			c_src_q <= '0;
			c_dst_q <= FBW'(32'(upd_row_q) * ROW_BYTES) + FBW'(upd_bx_q);
			fpos_q  <= '0;
		end
		if (state_q == S_COMP_RD) srd_q <= stage_mem[AW'(c_src_q)];
		if (clr_q) frame_mem[FA'(clr_addr_q)] <= 8'd0;
		else if (state_q == S_COMP_WR)
			frame_mem[disp_off + FA'(c_dst_q)] <= srd_q;
		if (state_q == S_COMP_WR) begin
			c_src_q <= c_src_q + 1'b1;
			if (c_col_q == upd_w_q - BW'(1)) begin
				c_col_q <= '0;
				c_row_q <= c_row_q + 1'b1;
				c_dst_q <= c_dst_q + FBW'(ROW_BYTES) - FBW'(upd_w_q) + 1'b1;
			end else begin
				c_col_q <= c_col_q + 1'b1;
				c_dst_q <= c_dst_q + 1'b1;
			end
		end
		if (state_q == S_TICK_RD) frd_q <= frame_mem[fa_rd];
		if (state_q == S_OUT) begin
			fpos_q <= fpos_q + 1'b1;
		end
	end

	// chunk position tracked as offset q mod CHUNK; first-chunk flag
	logic [CW-1:0] qmod_q;
	logic          past_first_q;
	always_ff @(posedge clk) begin
		if (state_q == S_RECV && acc_in && req_type == REQ_PIXEL) begin
			qmod_q <= '0;
			past_first_q <= 1'b0;
		end else if (state_q == S_OUT && fpos_q >= PW'(CMD_BYTES)) begin
			if (qmod_q == CW'(CHUNK_BYTES - 1)) begin
				qmod_q <= '0;
				past_first_q <= 1'b1;
			end else qmod_q <= qmod_q + 1'b1;
		end
	end

	// output register
	logic [2:0] cmd_k;
	always_comb begin
		cmd_k = 3'(fpos_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (acc_out) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_CHECK && chk_fail) begin
			ovalid_q <= 1'b1;
		end else if (state_q == S_DIV && !div_busy && w_bad) begin
			ovalid_q <= 1'b1;
		end else if (acc_in && req_type == REQ_HEADER && state_q == S_FLUSH) begin
			ovalid_q <= 1'b1;
		end else if (acc_in && req_type == REQ_PIXEL && state_q == S_RECV
			&& remain_q == 32'd1) begin
			ovalid_q <= 1'b1;
		end else if (state_q == S_OUT) begin
			ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ovalid_q) begin
			okind_q <= 1'b0; ost_q <= ST_DONE; obyte_q <= '0; och_q <= '0;
			ope_q <= 1'b0; ofe_q <= 1'b0;
			if (state_q == S_CHECK) ost_q <= chk_status;
			else if (state_q == S_DIV) ost_q <= ST_WIDTH;
			else if (state_q == S_FLUSH) ost_q <= ST_BUSY;
			else if (state_q == S_RECV)
				ost_q <= (zero_q && pixel_byte == 8'd0) ? ST_BLACK : ST_DONE;
			else if (state_q == S_OUT) begin
				okind_q <= 1'b1;
				if (fpos_q < PW'(CMD_BYTES)) begin
					och_q <= base;
					ope_q <= (cmd_k == 3'd2 || cmd_k == 3'd5);
					unique case (cmd_k)
						3'd0: obyte_q <= CMD_ROW_WIN;
						3'd3: obyte_q <= CMD_COL_WIN;
						3'd2: obyte_q <= ROWS_M1;
						3'd5: obyte_q <= COLS_M1;
						default: obyte_q <= CMD_ZERO;
					endcase
				end else begin
					obyte_q <= (fpos_q == PW'(CMD_BYTES)) ? CMD_RAM_WR : frd_q;
					och_q <= base | {1'b0, past_first_q};
					ofe_q <= (fpos_q == PW'(TOTAL - 1));
					ope_q <= (fpos_q == PW'(TOTAL - 1)) ||
						(qmod_q == CW'(CHUNK_BYTES - 1));
				end
			end
		end
	end

	assign out_valid   = ovalid_q;
	assign result_kind = okind_q;
	assign status      = ost_q;
	assign out_byte    = obyte_q;
	assign out_channel = och_q;
	assign packet_end  = ope_q;
	assign frame_end   = ofe_q;

	a_no_take_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall) else $error("item taken during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_byte) && out_valid)
		else $error("result changed under stall");
	a_fend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && fpos_q == PW'(TOTAL - 1)) |=> state_q == S_IDLE)
		else $error("flush did not end");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP_RD || state_q == S_DIV) |-> in_stall)
		else $error("input open while busy");
endmodule

### verif/display_partial_update_compositor_tb.sv
module display_partial_update_compositor_tb import dpuc_pkg::*;;

	localparam int ROWS  = 64;
	localparam int RB    = 170;
	localparam int CHUNK = 508;
	localparam int HDR   = 20;
	localparam int FB    = ROWS * RB;
	localparam int FLUSH_LEN = CMD_BYTES + 1 + FB;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int MAX_FLUSHES = 6;

	typedef enum int {PH_IDLE, PH_RECV, PH_FLUSH} phase_t;

	typedef struct {
		req_t        kind;
		bit          disp;
		bit [15:0]   row;
		bit [15:0]   col;
		bit [15:0]   cnt;
		bit [31:0]   pix;
		bit [31:0]   len;
		bit [7:0]    pb;
	} item_t;

	typedef struct {
		bit        kind;
		bit [2:0]  st;
		bit [7:0]  b;
		bit [1:0]  ch;
		bit        pe;
		bit        fe;
	} res_t;

	// Tracks the frame stores and the flush, and holds the results still due
	class flush_scoreboard;
		byte unsigned frame[2][FB];
		byte unsigned stage[FB];
		phase_t       phase;
		bit           dev;
		bit           disp;
		int unsigned  urow, uh, ubx, uw, remain, rcv, fpos;
		bit           zero;
		res_t         due[$];
		int           errors;

		function new();
			phase = PH_IDLE;
			zero = 1;
			errors = 0;
			dev = 0;
			disp = 0;
			urow = 0; uh = 0; ubx = 0; uw = 0; remain = 0; rcv = 0; fpos = 0;
			foreach (frame[d, i]) frame[d][i] = 0;
		endfunction

		function void push(bit k, bit [2:0] s, bit [7:0] b, bit [1:0] c, bit pe, bit fe);
			res_t r;
			r = '{k, s, b, c, pe, fe};
			due.push_back(r);
		endfunction

		task report(string s);
			$display("mismatch: %s", s);
			errors++;
		endtask

		function void take_header(item_t it);
			longint unsigned row, cnt, pix, len, bx, w;
			row = it.row;
			cnt = it.cnt;
			pix = it.pix;
			len = it.len;
			bx = (it.col / 3) * 2;
			phase = PH_IDLE;
			if (!dev) begin
				push(0, ST_NODEV, 0, 0, 0, 0);
				return;
			end
			if (len < HDR + 1) begin
				push(0, ST_SHORT, 0, 0, 0, 0);
				return;
			end
			if (cnt == 0 || row + cnt > ROWS) begin
				push(0, ST_ROWS, 0, 0, 0, 0);
				return;
			end
			if (pix == 0 || HDR + pix > len) begin
				push(0, ST_LENGTH, 0, 0, 0, 0);
				return;
			end
			w = pix / cnt;
			if (w == 0 || bx + w > RB) begin
				push(0, ST_WIDTH, 0, 0, 0, 0);
				return;
			end
			disp = it.disp;
			urow = row;
			uh = cnt;
			ubx = bx;
			uw = w;
			remain = pix;
			rcv = 0;
			zero = 1;
			phase = PH_RECV;
		endfunction

		function void take_pixel(bit [7:0] b);
			int unsigned dst, src;
			if (rcv < uh * uw && rcv < FB) stage[rcv] = b;
			if (rcv < FB) rcv++;
			if (b != 0) zero = 0;
			remain--;
			if (remain != 0) return;
			if (zero) begin
				phase = PH_IDLE;
				push(0, ST_BLACK, 0, 0, 0, 0);
				return;
			end
			// copy staged rows into the selected frame store
			for (int r = 0; r < uh; r++) begin
				dst = (urow + r) * RB + ubx;
				src = r * uw;
				if (dst + uw <= FB && src + uw <= FB)
					for (int i = 0; i < uw; i++) frame[disp][dst + i] = stage[src + i];
			end
			fpos = 0;
			phase = PH_FLUSH;
			push(0, ST_DONE, 0, 0, 0, 0);
		endfunction

		function void take_tick();
			int unsigned k, q;
			bit [1:0] base;
			bit [7:0] b;
			bit pe, fe;
			base = disp ? 2'd2 : 2'd0;
			if (fpos < CMD_BYTES) begin
				k = fpos % 3;
				if (k == 0) b = (fpos < 3) ? CMD_ROW_WIN : CMD_COL_WIN;
				else if (k == 1) b = CMD_ZERO;
				else b = (fpos < 3) ? 8'(ROWS - 1) : 8'(RB / 2 - 1);
				fpos++;
				push(1, ST_DONE, b, base, k == 2, 0);
				return;
			end
			q = fpos - CMD_BYTES;
			b = (q == 0) ? CMD_RAM_WR : frame[disp][(q - 1) % FB];
			fe = (q == FB);
			pe = fe || (q % CHUNK == CHUNK - 1);
			fpos++;
			if (fe || fpos >= FLUSH_LEN) phase = PH_IDLE;
			push(1, ST_DONE, b, base | ((q >= CHUNK) ? 2'd1 : 2'd0), pe, fe);
		endfunction

		// Accepted input transfer: work out what it causes
		function void note(item_t it);
			case (it.kind)
				REQ_HEADER: begin
					if (phase == PH_FLUSH) push(0, ST_BUSY, 0, 0, 0, 0);
					else take_header(it);
				end
				REQ_PIXEL: if (phase == PH_RECV && remain != 0) take_pixel(it.pb);
				REQ_TICK:  if (phase == PH_FLUSH) take_tick();
				default: ;
			endcase
		endfunction

		// Accepted output transfer: compare with the oldest result due
		task check(res_t r);
			res_t e;
			if (due.size() == 0) begin
				report($sformatf("unexpected result kind=%0d st=%0d b=%h", r.kind, r.st, r.b));
				return;
			end
			e = due.pop_front();
			if (r.kind != e.kind) report($sformatf("result_kind %0d, want %0d", r.kind, e.kind));
			if (r.st != e.st) report($sformatf("status %0d, want %0d", r.st, e.st));
			if (r.b != e.b) report($sformatf("out_byte %h, want %h", r.b, e.b));
			if (r.ch != e.ch) report($sformatf("out_channel %0d, want %0d", r.ch, e.ch));
			if (r.pe != e.pe) report($sformatf("packet_end %0d, want %0d", r.pe, e.pe));
			if (r.fe != e.fe) report($sformatf("frame_end %0d, want %0d", r.fe, e.fe));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_data = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_NONE;
	logic        display_select = 0;
	logic [15:0] row_origin = 0;
	logic [15:0] col_origin = 0;
	logic [15:0] row_count = 0;
	logic [31:0] pixel_count = 0;
	logic [31:0] message_length = 0;
	logic [7:0]  pixel_byte = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        result_kind;
	logic [2:0]  status;
	logic [7:0]  out_byte;
	logic [1:0]  out_channel;
	logic        packet_end;
	logic        frame_end;

	flush_scoreboard sb = new();
	bit calm = 0;
	int items = 0;
	int flushes = 0;
	int quiet_cycles = 0;

	display_partial_update_compositor u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .display_select(display_select),
		.row_origin(row_origin), .col_origin(col_origin), .row_count(row_count),
		.pixel_count(pixel_count), .message_length(message_length),
		.pixel_byte(pixel_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .status(status), .out_byte(out_byte),
		.out_channel(out_channel), .packet_end(packet_end), .frame_end(frame_end)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Output side: random stall, check each transfer
	always @(posedge clk) begin
		res_t r;
		if (out_valid && !out_stall) begin
			r = '{result_kind, status, out_byte, out_channel, packet_end, frame_end};
			sb.check(r);
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("display_partial_update_compositor_tb NOT OK");
			$finish;
		end
	end

	task send(item_t it);
		if (!calm && $urandom_range(99) < 21) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= it.kind;
		display_select <= it.disp;
		row_origin <= it.row;
		col_origin <= it.col;
		row_count <= it.cnt;
		pixel_count <= it.pix;
		message_length <= it.len;
		pixel_byte <= it.pb;
		do @(posedge clk); while (in_stall);
		sb.note(it);
		if (it.kind != REQ_TICK) items++;
	endtask

	function item_t noise(req_t k);
		item_t it;
		it.kind = k;
		it.disp = $urandom_range(1);
		it.row = $urandom;
		it.col = $urandom;
		it.cnt = $urandom;
		it.pix = $urandom;
		it.len = $urandom;
		it.pb = $urandom;
		return it;
	endfunction

	task send_hdr(bit d, int unsigned row, int unsigned col, int unsigned cnt,
			int unsigned pix, int unsigned len);
		item_t it;
		it = noise(REQ_HEADER);
		it.disp = d;
		it.row = row;
		it.col = col;
		it.cnt = cnt;
		it.pix = pix;
		it.len = len;
		send(it);
	endtask

	// Well-formed message; nsend below the byte count abandons it
	task send_msg(bit d, int unsigned row, int unsigned col, int unsigned cnt,
			int unsigned w, int unsigned extra, bit zeros, int nsend);
		item_t it;
		int unsigned pix;
		pix = cnt * w + extra;
		send_hdr(d, row, col, cnt, pix, HDR + pix + $urandom_range(3));
		for (int i = 0; i < pix && (nsend < 0 || i < nsend); i++) begin
			it = noise(REQ_PIXEL);
			if (zeros) it.pb = 0;
			else if (i == 0) it.pb = $urandom_range(1, 255);
			send(it);
		end
	endtask

	// Tick the flush through, with busy headers and stray bytes mixed in
	task run_flush(bit force_busy);
		flushes++;
		if (force_busy) send(noise(REQ_HEADER));
		while (sb.phase == PH_FLUSH) begin
			if ($urandom_range(999) < 3) send(noise(REQ_HEADER));
			else if ($urandom_range(999) < 3) send(noise(REQ_PIXEL));
			send(noise(REQ_TICK));
		end
	endtask

	task drain();
		in_valid <= 0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task write_dev(bit v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.dev = v;
	endtask

	task msg_random();
		int unsigned pick, cnt, w, k;
		pick = $urandom_range(99);
		if (pick < 60) begin
			cnt = ($urandom_range(19) == 0) ? $urandom_range(1, ROWS) : $urandom_range(1, 4);
			w = ($urandom_range(19) == 0) ? $urandom_range(1, RB) : $urandom_range(1, 8);
			if (cnt * w > 64) cnt = 1;
			k = $urandom_range((RB - w) / 2);
			send_msg($urandom_range(1), $urandom_range(ROWS - cnt), 3 * k + $urandom_range(2),
				cnt, w, $urandom_range(cnt - 1),
				flushes >= MAX_FLUSHES || $urandom_range(99) < 20,
				($urandom_range(9) == 0) ? int'($urandom_range(cnt * w)) : -1);
		end else if (pick < 85) begin
			send(noise(REQ_HEADER));
		end else begin
			send(noise(req_t'($urandom_range(1, 3))));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// no device: every header rejected, stray items ignored
		write_dev(0);
		send_hdr(0, 0, 0, 1, 1, 21);
		send(noise(REQ_TICK));
		send(noise(REQ_PIXEL));
		send(noise(REQ_NONE));
		write_dev(1);

		// each header rejection and the field extremes
		send_hdr(0, 0, 0, 1, 1, 20);
		send_hdr(1, 0, 0, 0, 1, 100);
		send_hdr(0, 63, 0, 2, 2, 100);
		send_hdr(1, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff);
		send_hdr(0, 0, 0, 1, 0, 100);
		send_hdr(1, 0, 0, 1, 81, 100);
		send_hdr(0, 0, 0, 4, 3, 100);
		send_hdr(1, 0, 16'hffff, 1, 1, 100);
		send_hdr(0, 0, 0, 1, 1, 32'hffffffff);
		// all-black update, abandoned message, then a right-edge update with surplus
		send_msg(0, 0, 0, 2, 3, 0, 1, -1);
		send_msg(1, 0, 0, 3, 2, 0, 0, 2);
		send_msg(1, 62, 252, 2, 2, 1, 0, -1);
		run_flush(1);
		send_msg(0, 0, 0, 1, RB, 0, 0, -1);
		run_flush(0);
		drain();

		// random messages; device off for a stretch, calm stretch, pauses
		while (items < 1050) begin
			calm = (items >= 400 && items < 550);
			msg_random();
			if (sb.phase == PH_FLUSH) run_flush(0);
			if (sb.phase == PH_IDLE && $urandom_range(99) < 2) begin
				if (items > 300 && items < 360 && sb.dev) write_dev(0);
				else if (items > 360 && !sb.dev) write_dev(1);
				else drain();
			end
		end
		calm = 0;
		drain();
		if (sb.due.size() != 0) sb.report("results still due at end");
		if (sb.errors == 0) begin
			$display("display_partial_update_compositor_tb OK");
		end else begin
			$display("display_partial_update_compositor_tb NOT OK");
		end
		$finish;
	end
endmodule
